// File: sv/cbtc_pkg.sv
`default_nettype none

package cbtc_pkg;

  localparam int BYTE_W = 8;
  localparam int KEY_DEPTH = 1 << BYTE_W;
  localparam int CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_KEY  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION  = 2'd0,
    REG_KEYED      = 2'd1,
    REG_CHAIN_SEED = 2'd2
  } reg_idx_t;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef struct packed {
    logic  direction;
    logic  keyed;
    byte_t chain_seed;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/chained_byte_table_cipher_core.sv
`default_nettype none

// Chained byte table cipher.
// Input channel (in_valid/in_ready) carries one beat per byte or key write:
// cmd selects a data byte or a key table write (key_index, key_value).
// Data beats give one data_out beat each on the output channel
// (out_valid/out_ready); key writes give none.
// A data byte is registered into data_out, with out_valid set, as it is accepted.
// Throughput: one beat per cycle while in_ready is high. The key table is read
// every cycle at the next chain byte and at the seed, so the addend is ready for
// the next beat; the chain loop closes through the registered key memory read port.
// A single output register parts the channels: in_ready is high while that
// register is empty or being drained, so a stalled receiver holds one
// result and stops the input after that.
// Reset clears configuration and the chain byte to zero and empties the
// output register. Key table contents are undefined until written; all
// entries must be loaded before keyed use. Configuration (cfg_we,
// cfg_index, cfg_data) is to be written while the block is idle; the block does not enforce this.
module chained_byte_table_cipher_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [cbtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cbtc_pkg::BYTE_W-1:0]       cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              cmd,
  input  wire logic                              start_req,
  input  wire logic [cbtc_pkg::BYTE_W-1:0]       data_in,
  input  wire logic [cbtc_pkg::BYTE_W-1:0]       key_index,
  input  wire logic [cbtc_pkg::BYTE_W-1:0]       key_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [cbtc_pkg::BYTE_W-1:0]            data_out
);

  cbtc_pkg::cfg_t  cfg;
  cbtc_pkg::cfg_t  cfg_next;
  cbtc_pkg::byte_t key_prev;
  cbtc_pkg::byte_t key_seed;
  cbtc_pkg::byte_t prev_plain_next;
  logic            key_we;

  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      case (cfg_index)
        cbtc_pkg::REG_DIRECTION:  cfg_next.direction  = cfg_data[0];
        cbtc_pkg::REG_KEYED:      cfg_next.keyed      = cfg_data[0];
        cbtc_pkg::REG_CHAIN_SEED: cfg_next.chain_seed = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

  assign key_we = in_valid && in_ready && (cmd == cbtc_pkg::CMD_KEY);

  // seed port follows the seed as written so it is valid the cycle after
  cbtc_key_mem u_key_mem (
    .clk     (clk),
    .rst     (rst),
    .we      (key_we),
    .waddr   (key_index),
    .wdata   (key_value),
    .raddr_a (prev_plain_next),
    .raddr_b (cfg_next.chain_seed),
    .rdata_a (key_prev),
    .rdata_b (key_seed)
  );

  cbtc_chain u_chain (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .key_prev        (key_prev),
    .key_seed        (key_seed),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .start_req       (start_req),
    .data_in         (data_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .data_out        (data_out),
    .prev_plain_next (prev_plain_next)
  );

endmodule

`default_nettype wire

// File: sv/cbtc_key_mem.sv
`default_nettype none

// Key table: one write port, two registered read ports. A write that hits
// the address read on the same edge is forwarded to that port's output.
module cbtc_key_mem (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            we,
  input  wire cbtc_pkg::byte_t waddr,
  input  wire cbtc_pkg::byte_t wdata,
  input  wire cbtc_pkg::byte_t raddr_a,
  input  wire cbtc_pkg::byte_t raddr_b,
  output cbtc_pkg::byte_t      rdata_a,
  output cbtc_pkg::byte_t      rdata_b
);

  cbtc_pkg::byte_t mem [cbtc_pkg::KEY_DEPTH];
  cbtc_pkg::byte_t mem_a;
  cbtc_pkg::byte_t mem_b;
  cbtc_pkg::byte_t wdata_q;
  logic            fwd_a;
  logic            fwd_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_a   <= mem[raddr_a];
    mem_b   <= mem[raddr_b];
    wdata_q <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
    end else begin
      fwd_a <= we && (waddr == raddr_a);
      fwd_b <= we && (waddr == raddr_b);
    end
  end

  assign rdata_a = fwd_a ? wdata_q : mem_a;
  assign rdata_b = fwd_b ? wdata_q : mem_b;

endmodule

`default_nettype wire

// File: sv/cbtc_chain.sv
`default_nettype none

// Chain datapath: addend select, add/subtract, chain register, output stage.
module cbtc_chain (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cbtc_pkg::cfg_t  cfg,
  input  wire cbtc_pkg::byte_t key_prev,
  input  wire cbtc_pkg::byte_t key_seed,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            cmd,
  input  wire logic            start_req,
  input  wire cbtc_pkg::byte_t data_in,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cbtc_pkg::byte_t      data_out,
  output cbtc_pkg::byte_t      prev_plain_next
);

  cbtc_pkg::byte_t prev_plain;
  cbtc_pkg::byte_t prev_sel;
  cbtc_pkg::byte_t addend;
  cbtc_pkg::byte_t result;
  logic            data_beat;

  assign in_ready  = !out_valid || out_ready;
  assign data_beat = in_valid && in_ready && (cmd == cbtc_pkg::CMD_DATA);

  always_comb begin
    prev_sel = start_req ? cfg.chain_seed : prev_plain;
    if (cfg.keyed) begin
      addend = start_req ? key_seed : key_prev;
    end else begin
      addend = prev_sel;
    end
    if (cfg.direction == cbtc_pkg::DIR_DECRYPT) begin
      result = data_in - addend;
    end else begin
      result = data_in + addend;
    end
    prev_plain_next = prev_plain;
    if (data_beat) begin
      // chain always follows the plaintext side
      prev_plain_next = (cfg.direction == cbtc_pkg::DIR_DECRYPT) ? result : data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_plain <= '0;
      out_valid  <= 1'b0;
    end else begin
      prev_plain <= prev_plain_next;
      if (data_beat) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_beat) begin
      data_out <= result;
    end
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = 4;

  typedef struct packed {
    cbtc_pkg::cmd_t  cmd;
    logic            start_req;
    cbtc_pkg::byte_t data;
    cbtc_pkg::byte_t kidx;
    cbtc_pkg::byte_t kval;
  } cipher_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_we = 1'b0;
  logic [cbtc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  cbtc_pkg::byte_t                cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           cmd = 1'b0;
  logic                           start_req = 1'b0;
  cbtc_pkg::byte_t                data_in = '0;
  cbtc_pkg::byte_t                key_index = '0;
  cbtc_pkg::byte_t                key_value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  cbtc_pkg::byte_t                data_out;

  chained_byte_table_cipher_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .start_req (start_req),
    .data_in   (data_in),
    .key_index (key_index),
    .key_value (key_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the cipher state
  cbtc_pkg::cfg_t  cfg_shadow = '0;
  cbtc_pkg::byte_t prev_plain_byte = '0;
  cbtc_pkg::byte_t key_shadow [cbtc_pkg::KEY_DEPTH];

  cipher_beat_t    pending_beats [$];
  cbtc_pkg::byte_t expected_bytes [$];

  int   n_errors = 0;
  int   idle_cycles = 0;
  int   tx_max_gap = 8;
  int   rx_max_stall = 8;
  int   tx_gap = 0;
  int   rx_wait = 0;
  int   rx_draw;
  int   hold_cnt = 0;
  int   hold_req_n = 0;
  int   hold_ack_n = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  cipher_beat_t    drv_beat;
  cipher_beat_t    seen_beat;
  cbtc_pkg::byte_t ciphered;
  cbtc_pkg::byte_t want_byte;

  // Returns 1 when the beat produces a data_out byte.
  function automatic logic cipher_step(input cipher_beat_t b,
                                       output cbtc_pkg::byte_t res);
    cbtc_pkg::byte_t chain_in;
    cbtc_pkg::byte_t addend;
    res = '0;
    if (b.cmd == cbtc_pkg::CMD_KEY) begin
      key_shadow[b.kidx] = b.kval;
      return 1'b0;
    end
    chain_in = b.start_req ? cfg_shadow.chain_seed : prev_plain_byte;
    addend = cfg_shadow.keyed ? key_shadow[chain_in] : chain_in;
    if (cfg_shadow.direction == cbtc_pkg::DIR_ENCRYPT) begin
      res = b.data + addend;
      prev_plain_byte = b.data;
    end else begin
      res = b.data - addend;
      // chain always follows the plaintext
      prev_plain_byte = res;
    end
    return 1'b1;
  endfunction

  function automatic cipher_beat_t data_beat(logic st, cbtc_pkg::byte_t d);
    cipher_beat_t b;
    b.cmd = cbtc_pkg::CMD_DATA;
    b.start_req = st;
    b.data = d;
    b.kidx = cbtc_pkg::byte_t'($urandom);
    b.kval = cbtc_pkg::byte_t'($urandom);
    return b;
  endfunction

  function automatic cipher_beat_t key_beat(cbtc_pkg::byte_t idx, cbtc_pkg::byte_t val);
    cipher_beat_t b;
    b.cmd = cbtc_pkg::CMD_KEY;
    b.start_req = 1'($urandom);
    b.data = cbtc_pkg::byte_t'($urandom);
    b.kidx = idx;
    b.kval = val;
    return b;
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the beat until it is taken
    end else if (tx_gap != 0) begin
      in_valid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (pending_beats.size() != 0) begin
      drv_beat = pending_beats.pop_front();
      cmd       <= drv_beat.cmd;
      start_req <= drv_beat.start_req;
      data_in   <= drv_beat.data;
      key_index <= drv_beat.kidx;
      key_value <= drv_beat.kval;
      in_valid  <= 1'b1;
      tx_gap    <= $urandom_range(0, tx_max_gap);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_ack_n != hold_req_n) begin
      hold_ack_n <= hold_req_n;
      hold_cnt <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= 1'b0;
    end else begin
      rx_draw = out_taken ? $urandom_range(0, rx_max_stall) : 0;
      if (rx_draw != 0) begin
        rx_wait <= rx_draw - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    in_taken  <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: data_out %02h with nothing expected", $time, data_out);
        n_errors++;
      end else begin
        want_byte = expected_bytes.pop_front();
        if (data_out !== want_byte) begin
          $display("%0t: data_out expected %02h got %02h", $time, want_byte, data_out);
          n_errors++;
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      seen_beat.cmd       = cbtc_pkg::cmd_t'(cmd);
      seen_beat.start_req = start_req;
      seen_beat.data      = data_in;
      seen_beat.kidx      = key_index;
      seen_beat.kval      = key_value;
      if (cipher_step(seen_beat, ciphered))
        expected_bytes.push_back(ciphered);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  task automatic write_reg(cbtc_pkg::reg_idx_t idx, cbtc_pkg::byte_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cbtc_pkg::REG_DIRECTION:  cfg_shadow.direction = val[0];
      cbtc_pkg::REG_KEYED:      cfg_shadow.keyed = val[0];
      cbtc_pkg::REG_CHAIN_SEED: cfg_shadow.chain_seed = val;
      default: ;
    endcase
  endtask

  // wait for every beat to go out and every result to come back
  task automatic drain;
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin : stimulus
    int n_data;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unkeyed encrypt from reset: first beat chains on the cleared byte
    pending_beats.push_back(data_beat(1'b0, 8'h5A));
    pending_beats.push_back(data_beat(1'b0, 8'hFF));
    pending_beats.push_back(data_beat(1'b0, 8'h00));
    pending_beats.push_back(data_beat(1'b1, 8'h80));
    pending_beats.push_back(data_beat(1'b0, 8'hFF));
    drain();

    // switch to decrypt mid-stream, seed at top
    write_reg(cbtc_pkg::REG_DIRECTION, 8'(cbtc_pkg::DIR_DECRYPT));
    write_reg(cbtc_pkg::REG_CHAIN_SEED, 8'hFF);
    pending_beats.push_back(data_beat(1'b0, 8'h11));
    pending_beats.push_back(data_beat(1'b1, 8'h00));
    pending_beats.push_back(data_beat(1'b0, 8'hFF));
    pending_beats.push_back(data_beat(1'b0, 8'h7F));
    drain();

    // fill the whole key table before any keyed use
    for (int i = 0; i < cbtc_pkg::KEY_DEPTH; i++) begin
      if (i == 0)
        pending_beats.push_back(key_beat(8'h00, 8'hFF));
      else if (i == cbtc_pkg::KEY_DEPTH - 1)
        pending_beats.push_back(key_beat(8'hFF, 8'h00));
      else
        pending_beats.push_back(key_beat(cbtc_pkg::byte_t'(i),
                                         cbtc_pkg::byte_t'($urandom)));
    end
    drain();

    write_reg(cbtc_pkg::REG_KEYED, 8'h01);
    write_reg(cbtc_pkg::REG_DIRECTION, 8'(cbtc_pkg::DIR_ENCRYPT));
    write_reg(cbtc_pkg::REG_CHAIN_SEED, 8'h00);
    pending_beats.push_back(data_beat(1'b1, 8'h00));
    pending_beats.push_back(data_beat(1'b0, 8'hFF));
    pending_beats.push_back(data_beat(1'b0, 8'h33));
    pending_beats.push_back(data_beat(1'b0, 8'hC4));
    drain();

    write_reg(cbtc_pkg::REG_DIRECTION, 8'(cbtc_pkg::DIR_DECRYPT));
    write_reg(cbtc_pkg::REG_CHAIN_SEED, 8'hFF);
    pending_beats.push_back(data_beat(1'b1, 8'hFF));
    pending_beats.push_back(data_beat(1'b0, 8'h00));
    pending_beats.push_back(data_beat(1'b0, 8'h01));
    // key rewrite in the middle of a stream leaves the chain alone
    pending_beats.push_back(key_beat(cbtc_pkg::byte_t'($urandom),
                                     cbtc_pkg::byte_t'($urandom)));
    pending_beats.push_back(data_beat(1'b0, cbtc_pkg::byte_t'($urandom)));
    drain();

    // random streams, one register setting per phase
    for (int p = 0; p < 8; p++) begin
      write_reg(cbtc_pkg::REG_DIRECTION, cbtc_pkg::byte_t'(p[0]));
      write_reg(cbtc_pkg::REG_KEYED, cbtc_pkg::byte_t'(p[1]));
      write_reg(cbtc_pkg::REG_CHAIN_SEED,
                (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : cbtc_pkg::byte_t'($urandom));
      tx_max_gap   = (p % 4 == 3) ? 0 : 8;
      rx_max_stall = (p % 4 == 3) ? 0 : 8;
      n_data = 0;
      while (n_data < 90) begin
        if ($urandom_range(0, 99) < 8) begin
          pending_beats.push_back(key_beat(cbtc_pkg::byte_t'($urandom),
                                           cbtc_pkg::byte_t'($urandom)));
        end else begin
          pending_beats.push_back(data_beat($urandom_range(0, 99) < 12,
                                            cbtc_pkg::byte_t'($urandom)));
          n_data++;
        end
      end
      // long receiver stall so the core backs up onto the input
      if (p == 2)
        hold_req_n++;
      drain();
    end

    repeat (10) @(posedge clk);
    if (n_errors == 0 && expected_bytes.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
